[sv/lz_rle_multimode_depacker_defines.svh]
// assertion macros for the depacker
`ifndef LZ_RLE_MULTIMODE_DEPACKER_DEFINES_SVH
`define LZ_RLE_MULTIMODE_DEPACKER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LZRLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LZRLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LZRLE_ASSERT_NOW(label, ante, cons)
`define LZRLE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/lzrle_pkg.sv]
package lzrle_pkg;

    localparam int OUTPUT_LIMIT_DEF = 49152;
    localparam int HIST_DEPTH = 65536;
    localparam int HIST_AW = $clog2(HIST_DEPTH);

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_EMIT  = 2'd2,
        CMD_END   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_CTRL = 3'd0,
        PH_LEN  = 3'd1,
        PH_ARG0 = 3'd2,
        PH_ARG1 = 3'd3,
        PH_ARG2 = 3'd4,
        PH_OUT  = 3'd5,
        PH_NEED = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ES_RUN    = 2'd0,
        ES_FIN    = 2'd1,
        ES_BADOFF = 2'd2,
        ES_EARLY  = 2'd3
    } end_t;

    typedef enum logic [3:0] {
        K_LIT  = 4'd0,
        K_FILL = 4'd1,
        K_PROG = 4'd2,
        K_PAT2 = 4'd3,
        K_PAT3 = 4'd4,
        K_MIX2 = 4'd5,
        K_MIX3 = 4'd6,
        K_NIB  = 4'd7,
        K_COPY = 4'd8
    } kind_t;

    localparam logic [2:0] ST_WORKING = 3'd0;
    localparam logic [2:0] ST_WANTS   = 3'd1;
    localparam logic [2:0] ST_DONE    = 3'd2;
    localparam logic [2:0] ST_BADOFF  = 3'd3;
    localparam logic [2:0] ST_EARLY   = 3'd4;

    typedef struct packed {
        logic [15:0] produced_len;
        logic [15:0] chunks_left;
        logic [15:0] back_distance;
        logic [15:0] used_count;
        logic [4:0]  op_kind;
        phase_t      phase;
        logic [11:0] run_left;
        logic [7:0]  param_a;
        logic [7:0]  param_b;
        logic [7:0]  param_c;
        end_t        end_state;
        logic [1:0]  slot;
        logic        input_done;
    } state_t;

    typedef struct packed {
        logic                emit;
        logic                copy;
        logic [7:0]          byte_val;
        logic [HIST_AW-1:0]  rd_addr;
        logic [HIST_AW-1:0]  wr_addr;
        logic [2:0]          status;
    } step_res_t;

    function automatic kind_t kind_of(logic [4:0] op);
        kind_t k;
        unique case (op) inside
            5'd0, 5'd1:    k = K_LIT;
            [5'd2:5'd7]:   k = K_FILL;
            5'd8, 5'd9:    k = K_PROG;
            5'd10, 5'd11:  k = K_PAT2;
            5'd12, 5'd13:  k = K_PAT3;
            5'd14, 5'd15:  k = K_MIX2;
            5'd16, 5'd17:  k = K_MIX3;
            5'd18, 5'd19:  k = K_NIB;
            default:       k = K_COPY;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] nargs_of(logic [4:0] op);
        logic [1:0] n;
        unique case (op) inside
            [5'd0:5'd5]:   n = 2'd0;
            [5'd8:5'd11]:  n = 2'd2;
            5'd12, 5'd13:  n = 2'd3;
            5'd22, 5'd23:  n = 2'd2;
            default:       n = 2'd1;
        endcase
        return n;
    endfunction

    function automatic logic [11:0] adj_of(logic [4:0] op);
        logic [11:0] a;
        unique case (op) inside
            5'd0:                     a = 12'hffe;
            5'd2, 5'd4, 5'd10, 5'd12: a = 12'hfff;
            5'd8, 5'd22:              a = 12'h001;
            default:                  a = 12'h000;
        endcase
        return a;
    endfunction

    function automatic logic [1:0] group_of(kind_t k);
        logic [1:0] g;
        unique case (k) inside
            K_PAT2, K_MIX2, K_NIB: g = 2'd2;
            K_PAT3, K_MIX3:        g = 2'd3;
            default:               g = 2'd1;
        endcase
        return g;
    endfunction

    function automatic logic slot_fresh(kind_t k, logic [1:0] s);
        return (k == K_LIT && s == 2'd0) || (k == K_MIX2 && s == 2'd1) ||
               (k == K_MIX3 && s != 2'd0) || (k == K_NIB && s == 2'd0);
    endfunction

    function automatic state_t enter_slot(state_t s);
        state_t r;
        r = s;
        r.phase = slot_fresh(kind_of(s.op_kind), s.slot) ? PH_NEED : PH_OUT;
        return r;
    endfunction

    function automatic state_t start_run(state_t s);
        state_t r;
        r = s;
        if (kind_of(s.op_kind) == K_COPY &&
            (s.back_distance == 16'd0 || s.back_distance > s.produced_len))
        begin
            r.end_state = ES_BADOFF;
        end
        else if (s.run_left == 12'd0)
        begin
            r.phase = PH_CTRL;
            r.slot = 2'd0;
        end
        else
        begin
            r.slot = 2'd0;
            r = enter_slot(r);
        end
        return r;
    endfunction

    function automatic state_t begin_args(state_t s);
        state_t r;
        r = s;
        if (s.op_kind == 5'd2 || s.op_kind == 5'd3)
            r.param_a = 8'h00;
        if (s.op_kind == 5'd4 || s.op_kind == 5'd5)
            r.param_a = 8'hff;
        if (nargs_of(s.op_kind) == 2'd0)
            r = start_run(r);
        else
            r.phase = PH_ARG0;
        return r;
    endfunction

    function automatic state_t settle(state_t s, logic [15:0] limit);
        state_t r;
        r = s;
        if (s.end_state == ES_RUN)
        begin
            if (s.phase == PH_CTRL)
            begin
                if (s.chunks_left == 16'd0 || s.produced_len >= limit)
                    r.end_state = ES_FIN;
                else if (s.input_done)
                    r.end_state = (s.used_count == 16'd0) ? ES_FIN : ES_EARLY;
            end
            else if (s.phase != PH_OUT && s.input_done)
            begin
                r.end_state = ES_EARLY;
            end
        end
        return r;
    endfunction

    function automatic state_t take_byte(state_t s, logic [7:0] b);
        state_t r;
        logic [1:0] idx;
        logic [4:0] op;
        r = s;
        op = s.op_kind;
        idx = 2'(s.phase - PH_ARG0);
        if (s.used_count != 16'hffff)
            r.used_count = s.used_count + 16'd1;
        case (s.phase)
            PH_CTRL:
            begin
                r.chunks_left = s.chunks_left - 16'd1;
                r.op_kind = b[4:0];
                if (b[4:3] == 2'b11)
                begin
                    r.run_left = {9'd0, b[7:5]} + 12'd3;
                    r.back_distance = {5'd0, b[2:0], 8'd0};
                    r = begin_args(r);
                end
                else if (b[0])
                begin
                    r.param_a = {5'd0, b[7:5]};
                    r.phase = PH_LEN;
                end
                else
                begin
                    r.run_left = {9'd0, b[7:5]} + 12'd3 + adj_of(b[4:0]);
                    r = begin_args(r);
                end
            end
            PH_LEN:
            begin
                r.run_left = {s.param_a[3:0], b};
                r = begin_args(r);
            end
            PH_ARG0, PH_ARG1, PH_ARG2:
            begin
                if (kind_of(op) == K_COPY)
                begin
                    if (op >= 5'h18)
                        r.back_distance = s.back_distance | {8'd0, b};
                    else if (op >= 5'h16 && idx == 2'd0)
                        r.back_distance = {b, 8'd0};
                    else if (op >= 5'h16)
                        r.back_distance = s.back_distance | {8'd0, b};
                    else
                        r.back_distance = {8'd0, b};
                end
                else if (idx == 2'd0)
                    r.param_a = b;
                else if (idx == 2'd1)
                    r.param_b = b;
                else
                    r.param_c = b;
                if ({1'b0, idx} + 3'd1 >= {1'b0, nargs_of(op)})
                    r = start_run(r);
                else
                    r.phase = phase_t'(s.phase + 3'd1);
            end
            PH_NEED:
            begin
                r.param_b = b;
                r.phase = PH_OUT;
            end
            default:
            begin
                r = s;
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] emit_value(state_t s);
        logic [7:0] v;
        kind_t k;
        k = kind_of(s.op_kind);
        case (k)
            K_LIT:  v = s.param_b;
            K_FILL, K_PROG: v = s.param_a;
            K_PAT2, K_MIX2, K_MIX3: v = (s.slot == 2'd0) ? s.param_a : s.param_b;
            K_PAT3: v = (s.slot == 2'd0) ? s.param_a :
                        ((s.slot == 2'd1) ? s.param_b : s.param_c);
            K_NIB:  v = s.param_a + ((s.slot == 2'd0) ? {4'd0, s.param_b[7:4]}
                                                      : {4'd0, s.param_b[3:0]});
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic state_t emit_step(state_t s);
        state_t r;
        kind_t k;
        r = s;
        k = kind_of(s.op_kind);
        if (k == K_PROG)
            r.param_a = s.param_a + s.param_b;
        r.produced_len = s.produced_len + 16'd1;
        r.slot = s.slot + 2'd1;
        if (r.slot >= group_of(k))
        begin
            r.slot = 2'd0;
            r.run_left = s.run_left - 12'd1;
            if (r.run_left == 12'd0)
                r.phase = PH_CTRL;
            else
                r = enter_slot(r);
        end
        else
        begin
            r = enter_slot(r);
        end
        return r;
    endfunction

endpackage

[sv/lz_rle_multimode_depacker.sv]
// latency: a result appears in the cycle after its item is accepted
// throughput: one item per cycle while in_stall is low, copies included; history reads are forwarded
// from the write still in flight, so back-to-back copies at distance one run at full rate
// reset: asynchronous, active low; clears control state and the result valid flag,
// the history memory is not cleared and the block reports finished until started
`include "lz_rle_multimode_depacker_defines.svh"

module lz_rle_multimode_depacker
    import lzrle_pkg::*;
#(
    parameter int OUTPUT_LIMIT = OUTPUT_LIMIT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        chunk_count_we,
    input  logic [15:0] chunk_count,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  out_byte,
    output logic        out_valid,
    output logic [2:0]  status,
    output logic [15:0] out_length,
    output logic [15:0] consumed_bytes
);

    logic               accept;
    step_res_t          res;
    logic [15:0]        len_next;
    logic [15:0] used_next;
    logic [7:0]         rd_data;
    logic [7:0]         cur_byte;

    logic               res_valid_reg;
    logic               emit_reg;
    logic               copy_reg;
    logic [7:0]         byte_reg;
    logic [2:0]         status_reg;
    logic [15:0]        len_reg;
    logic [15:0]        used_reg;
    logic               fwd_reg;
    logic [7:0]         fwd_byte_reg;
    logic               wr_pend_reg;
    logic [HIST_AW-1:0] wr_addr_reg;

    assign in_stall = res_valid_reg && res_stall;
    assign accept = in_valid && !in_stall;

    lzrle_ctrl #(
        .OUTPUT_LIMIT(OUTPUT_LIMIT)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (chunk_count_we),
        .cfg_data       (chunk_count),
        .accept         (accept),
        .cmd            (cmd),
        .data_byte      (data_byte),
        .res            (res),
        .out_length     (len_next),
        .consumed_bytes (used_next)
    );

    lzrle_hist u_hist (
        .clk     (clk),
        .wr_en   (wr_pend_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (cur_byte),
        .rd_en   (accept && res.copy),
        .rd_addr (res.rd_addr),
        .rd_data (rd_data)
    );

    assign cur_byte = copy_reg ? (fwd_reg ? fwd_byte_reg : rd_data) : byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
            emit_reg <= 1'b0;
            copy_reg <= 1'b0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= accept || (res_valid_reg && res_stall);
            wr_pend_reg <= accept && res.emit;
            if (accept)
            begin
                emit_reg <= res.emit;
                copy_reg <= res.copy;
                fwd_reg <= res.copy && wr_pend_reg && (res.rd_addr == wr_addr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= res.byte_val;
            status_reg <= res.status;
            len_reg <= len_next;
            used_reg <= used_next;
            fwd_byte_reg <= cur_byte;
            wr_addr_reg <= res.wr_addr;
        end
    end

    assign res_valid = res_valid_reg;
    assign out_byte = emit_reg ? cur_byte : 8'd0;
    assign out_valid = emit_reg;
    assign status = status_reg;
    assign out_length = len_reg;
    assign consumed_bytes = used_reg;

    `LZRLE_ASSERT_NOW(a_write_with_result, wr_pend_reg, res_valid_reg)
    `LZRLE_ASSERT_NOW(a_fwd_only_copy, res_valid_reg && fwd_reg, copy_reg && emit_reg)
    `LZRLE_ASSERT_NEXT(a_emit_counts, accept && res.emit, out_length != 16'd0)

endmodule

[sv/lzrle_hist.sv]
module lzrle_hist
    import lzrle_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [HIST_AW-1:0] wr_addr,
    input  logic [7:0]         wr_data,
    input  logic               rd_en,
    input  logic [HIST_AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] mem [HIST_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/lzrle_ctrl.sv]
module lzrle_ctrl
    import lzrle_pkg::*;
#(
    parameter int OUTPUT_LIMIT = OUTPUT_LIMIT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        accept,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    output step_res_t   res,
    output logic [15:0] out_length,
    output logic [15:0] consumed_bytes
);

    state_t      state_reg;
    state_t      state_next;
    logic [15:0] chunk_count_reg;
    state_t      s;

    always_comb
    begin
        s = settle(state_reg, 16'(OUTPUT_LIMIT));
        res = '0;
        case (cmd_t'(cmd))
            CMD_START:
            begin
                s.produced_len = 16'd0;
                s.used_count = 16'd0;
                s.chunks_left = chunk_count_reg;
                s.end_state = ES_RUN;
                s.input_done = 1'b0;
                s.slot = 2'd0;
                s.phase = PH_CTRL;
            end
            CMD_BYTE:
            begin
                if (s.end_state == ES_RUN && !s.input_done && s.phase != PH_OUT)
                    s = take_byte(s, data_byte);
            end
            CMD_EMIT:
            begin
                if (s.end_state == ES_RUN && s.phase == PH_OUT)
                begin
                    res.emit = 1'b1;
                    res.copy = (kind_of(s.op_kind) == K_COPY);
                    res.byte_val = emit_value(s);
                    res.rd_addr = HIST_AW'(s.produced_len - s.back_distance);
                    res.wr_addr = HIST_AW'(s.produced_len);
                    s = emit_step(s);
                end
            end
            default:
            begin
                s.input_done = 1'b1;
            end
        endcase
        s = settle(s, 16'(OUTPUT_LIMIT));
        case (s.end_state)
            ES_FIN:    res.status = ST_DONE;
            ES_BADOFF: res.status = ST_BADOFF;
            ES_EARLY:  res.status = ST_EARLY;
            default:   res.status = (s.phase == PH_OUT) ? ST_WORKING : ST_WANTS;
        endcase
        state_next = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            chunk_count_reg <= '0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (cfg_we)
                chunk_count_reg <= cfg_data;
        end
    end

    assign out_length = state_next.produced_len;
    assign consumed_bytes = state_next.used_count;

endmodule

[dv/tb_lz_rle_multimode_depacker.sv]
`timescale 1ns / 1ps

module tb_lz_rle_multimode_depacker;
    import lzrle_pkg::*;

    typedef struct {
        logic [7:0]  ob;
        logic        ov;
        logic [2:0]  st;
        logic [15:0] olen;
        logic [15:0] used;
    } depack_out_t;

    class depack_scoreboard;
        depack_out_t pending[$];
        int errors;
        int fails;
        logic [15:0] cfg_chunks;
        logic [7:0]  hist [int];
        logic [15:0] plen, left, back_dist, used;
        logic [4:0]  op;
        phase_t      ph;
        logic [11:0] run;
        logic [7:0]  pa, pb, pc;
        end_t        es;
        logic [1:0]  slot;
        logic        done_in;

        function new();
            cfg_chunks = 0; plen = 0; left = 0; back_dist = 0; used = 0; op = 0;
            ph = PH_CTRL; run = 0; pa = 0; pb = 0; pc = 0; es = ES_RUN;
            slot = 0; done_in = 0; errors = 0; fails = 0;
        endfunction

        function kind_t kind();
            if (op < 2) return K_LIT;
            if (op < 8) return K_FILL;
            if (op < 10) return K_PROG;
            if (op < 12) return K_PAT2;
            if (op < 14) return K_PAT3;
            if (op < 16) return K_MIX2;
            if (op < 18) return K_MIX3;
            if (op < 20) return K_NIB;
            return K_COPY;
        endfunction

        function int nargs(logic [4:0] o);
            if (o <= 5) return 0;
            if (o >= 8 && o <= 11) return 2;
            if (o == 12 || o == 13) return 3;
            if (o == 22 || o == 23) return 2;
            return 1;
        endfunction

        function int adjust(logic [4:0] o);
            case (o)
                0: return -2;
                2, 4, 10, 12: return -1;
                8, 22: return 1;
                default: return 0;
            endcase
        endfunction

        function int group_size(kind_t k);
            if (k == K_PAT2 || k == K_MIX2 || k == K_NIB) return 2;
            if (k == K_PAT3 || k == K_MIX3) return 3;
            return 1;
        endfunction

        function void pick_slot();
            kind_t k;
            k = kind();
            if ((k == K_LIT && slot == 0) || (k == K_MIX2 && slot == 1) ||
                (k == K_MIX3 && slot >= 1) || (k == K_NIB && slot == 0))
                ph = PH_NEED;
            else
                ph = PH_OUT;
        endfunction

        function void run_start();
            if (kind() == K_COPY && (back_dist == 0 || back_dist > plen))
            begin
                es = ES_BADOFF;
                return;
            end
            if (run == 0)
            begin
                ph = PH_CTRL;
                slot = 0;
                return;
            end
            slot = 0;
            pick_slot();
        endfunction

        function void args_begin();
            if (op == 2 || op == 3) pa = 8'h00;
            if (op == 4 || op == 5) pa = 8'hff;
            if (nargs(op) == 0) run_start(); else ph = PH_ARG0;
        endfunction

        function void settle();
            if (es != ES_RUN) return;
            if (ph == PH_CTRL)
            begin
                if (left == 0 || plen >= 16'hc000) es = ES_FIN;
                else if (done_in) es = (used == 0) ? ES_FIN : ES_EARLY;
            end
            else if (ph != PH_OUT && done_in)
                es = ES_EARLY;
        endfunction

        function void absorb(logic [7:0] b);
            int idx;
            if (used != 16'hffff) used++;
            if (ph == PH_CTRL)
            begin
                left--;
                op = b[4:0];
                if (b[4:3] == 2'b11)
                begin
                    run = 12'(b[7:5]) + 12'd3;
                    back_dist = {5'd0, b[2:0], 8'd0};
                    args_begin();
                end
                else if (b[0])
                begin
                    pa = {5'd0, b[7:5]};
                    ph = PH_LEN;
                end
                else
                begin
                    run = 12'(int'(b[7:5]) + 3 + adjust(op));
                    args_begin();
                end
            end
            else if (ph == PH_LEN)
            begin
                run = {pa[3:0], b};
                args_begin();
            end
            else if (ph >= PH_ARG0 && ph < PH_OUT)
            begin
                idx = ph - PH_ARG0;
                if (kind() == K_COPY)
                begin
                    if (op >= 5'h18) back_dist = back_dist | {8'd0, b};
                    else if (op >= 5'h16 && idx == 0) back_dist = {b, 8'd0};
                    else if (op >= 5'h16) back_dist = back_dist | {8'd0, b};
                    else back_dist = {8'd0, b};
                end
                else if (idx == 0) pa = b;
                else if (idx == 1) pb = b;
                else pc = b;
                if (idx + 1 >= nargs(op)) run_start(); else ph = phase_t'(ph + 1);
            end
            else if (ph == PH_NEED)
            begin
                pb = b;
                ph = PH_OUT;
            end
        endfunction

        function logic [7:0] produce();
            kind_t k;
            logic [7:0] v;
            k = kind();
            case (k)
                K_LIT: v = pb;
                K_FILL: v = pa;
                K_PROG:
                begin
                    v = pa;
                    pa = pa + pb;
                end
                K_PAT2, K_MIX2, K_MIX3: v = (slot == 0) ? pa : pb;
                K_PAT3: v = (slot == 0) ? pa : ((slot == 1) ? pb : pc);
                K_NIB: v = pa + ((slot == 0) ? {4'd0, pb[7:4]} : {4'd0, pb[3:0]});
                default: v = hist[int'(16'(plen - back_dist))];
            endcase
            hist[int'(plen)] = v;
            plen++;
            slot++;
            if (slot >= group_size(k))
            begin
                slot = 0;
                run = run - 12'd1;
                if (run == 0)
                begin
                    ph = PH_CTRL;
                    return v;
                end
            end
            pick_slot();
            return v;
        endfunction

        function void note_item(cmd_t c, logic [7:0] b);
            depack_out_t e;
            e.ob = 0;
            e.ov = 0;
            settle();
            case (c)
                CMD_START:
                begin
                    plen = 0; used = 0; left = cfg_chunks; es = ES_RUN;
                    done_in = 0; slot = 0; ph = PH_CTRL;
                end
                CMD_BYTE:
                    if (es == ES_RUN && !done_in && ph != PH_OUT) absorb(b);
                CMD_EMIT:
                    if (es == ES_RUN && ph == PH_OUT)
                    begin
                        e.ob = produce();
                        e.ov = 1;
                    end
                default: done_in = 1;
            endcase
            settle();
            case (es)
                ES_FIN: e.st = ST_DONE;
                ES_BADOFF: e.st = ST_BADOFF;
                ES_EARLY: e.st = ST_EARLY;
                default: e.st = (ph == PH_OUT) ? ST_WORKING : ST_WANTS;
            endcase
            e.olen = plen;
            e.used = used;
            pending.push_back(e);
        endfunction

        function void check_result(depack_out_t a);
            depack_out_t e;
            if (pending.size() == 0)
            begin
                fails++;
                if (errors++ < 10) $display("unexpected result at %0t", $realtime);
                return;
            end
            e = pending.pop_front();
            if (a.ob !== e.ob || a.ov !== e.ov || a.st !== e.st || a.olen !== e.olen ||
                a.used !== e.used)
            begin
                fails++;
                if (errors++ < 10)
                begin
                    $display("mismatch at %0t: exp byte %h v %b st %0d len %0d used %0d",
                        $realtime, e.ob, e.ov, e.st, e.olen, e.used);
                    $display("    got byte %h v %b st %0d len %0d used %0d",
                        a.ob, a.ov, a.st, a.olen, a.used);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        chunk_count_we;
    logic [15:0] chunk_count;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [2:0]  status;
    logic [15:0] out_length;
    logic [15:0] consumed_bytes;

    depack_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int items_sent = 0;
    logic [7:0] stream[$];

    lz_rle_multimode_depacker dut (
        .clk(clk),
        .rst_n(rst_n),
        .chunk_count_we(chunk_count_we),
        .chunk_count(chunk_count),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .data_byte(data_byte),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .out_byte(out_byte),
        .out_valid(out_valid),
        .status(status),
        .out_length(out_length),
        .consumed_bytes(consumed_bytes)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // receiver side
    always @(posedge clk)
    begin
        depack_out_t a;
        if (rst_n && res_valid && !res_stall)
        begin
            a.ob = out_byte;
            a.ov = out_valid;
            a.st = status;
            a.olen = out_length;
            a.used = consumed_bytes;
            sb.check_result(a);
        end
    end

    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_cycles <= 200;
            res_stall <= 1;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res_stall <= 1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_item(cmd_t c, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        cmd <= c;
        data_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_item(c, b);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic go_idle();
        in_valid <= 0;
    endtask

    task automatic write_chunks(logic [15:0] v);
        go_idle();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        chunk_count_we <= 1;
        chunk_count <= v;
        sb.cfg_chunks = v;
        @(negedge clk);
        chunk_count_we <= 0;
    endtask

    // feeds the queued stream, pulling output whenever a byte is ready
    task automatic feed_stream(int emits_per_byte);
        while (stream.size() != 0)
        begin
            if (sb.ph == PH_OUT && sb.es == ES_RUN)
                send_item(CMD_EMIT, 8'($urandom));
            else
                send_item(CMD_BYTE, stream.pop_front());
        end
        repeat (emits_per_byte) send_item(CMD_EMIT, 8'd0);
    endtask

    function automatic int adjust_of(logic [4:0] o);
        return sb.adjust(o);
    endfunction

    // builds one random well-formed chunk; copies stay within produced output
    task automatic make_chunk(inout int produced);
        logic [7:0] c;
        logic [4:0] o;
        int n, d, i;
        o = 5'($urandom_range(31));
        c = {3'($urandom), o};
        if (o[4:3] == 2'b11)
        begin
            d = (produced > 0) ? $urandom_range(produced < 255 ? produced : 255, 1) : 0;
            if (produced == 0) c[4:0] = 5'd2;
            else
            begin
                c[2:0] = 0;
                stream.push_back(c);
                stream.push_back(8'(d));
                produced += c[7:5] + 3;
                return;
            end
            o = c[4:0];
        end
        if (o >= 20 && produced == 0)
        begin
            o = 5'd6;
            c[4:0] = o;
        end
        if (o[0] && o[4:3] != 2'b11)
        begin
            c[7:5] = 0;
            stream.push_back(c);
            n = $urandom_range(6);
            stream.push_back(8'(n));
        end
        else
        begin
            stream.push_back(c);
            n = c[7:5] + 3 + adjust_of(o);
        end
        if (o >= 20)
        begin
            d = $urandom_range(produced < 255 ? produced : 255, 1);
            if (o >= 22 && o <= 23)
            begin
                stream.push_back(8'd0);
                stream.push_back(8'(d));
            end
            else
                stream.push_back(8'(d));
            produced += n;
            return;
        end
        for (i = 0; i < nargs_of(o); i++) stream.push_back(8'($urandom));
        for (i = 0; i < n * sb.group_size(kind_of(o)); i++)
            if ((kind_of(o) == K_LIT) ||
                (kind_of(o) == K_MIX2 && i % 2 == 1) ||
                (kind_of(o) == K_MIX3 && i % 3 != 0) ||
                (kind_of(o) == K_NIB && i % 2 == 0))
                stream.push_back(8'($urandom));
        produced += n * sb.group_size(kind_of(o));
    endtask

    task automatic random_stream(int nchunks);
        int produced, i;
        produced = 0;
        write_chunks(16'(nchunks));
        send_item(CMD_START, 8'($urandom));
        for (i = 0; i < nchunks; i++) make_chunk(produced);
        feed_stream(2);
        if ($urandom_range(3) == 0) send_item(CMD_END, 8'($urandom));
    endtask

    task automatic noise_items(int n);
        repeat (n) send_item(cmd_t'(2'($urandom_range(3))), 8'($urandom));
    endtask

    initial
    begin
        int phase_no, sent;
        sb = new();
        rst_n = 0;
        chunk_count_we = 0;
        chunk_count = 0;
        in_valid = 0;
        cmd = CMD_EMIT;
        data_byte = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: unstarted, empty stream, a bad offset, early end, zero chunk count
        send_item(CMD_EMIT, 0);
        send_item(CMD_BYTE, 8'hff);
        write_chunks(16'hffff);
        send_item(CMD_START, 0);
        send_item(CMD_END, 0);
        send_item(CMD_START, 0);
        send_item(CMD_BYTE, 8'h14);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_START, 0);
        send_item(CMD_BYTE, 8'hc6);
        send_item(CMD_BYTE, 8'h7e);
        send_item(CMD_EMIT, 0);
        send_item(CMD_BYTE, 8'h55);
        send_item(CMD_EMIT, 0);
        send_item(CMD_BYTE, 8'h03);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'h1f);
        send_item(CMD_BYTE, 8'h05);
        send_item(CMD_START, 0);
        send_item(CMD_BYTE, 8'h08);
        send_item(CMD_END, 0);
        send_item(CMD_EMIT, 0);
        write_chunks(0);
        send_item(CMD_START, 0);
        send_item(CMD_BYTE, 8'h00);

        for (phase_no = 0; phase_no < 3; phase_no++)
        begin
            send_idle_pct = (phase_no == 0) ? 11 : (phase_no == 1) ? 63 : 0;
            recv_idle_pct = (phase_no == 0) ? 63 : (phase_no == 1) ? 11 : 0;
            sent = items_sent;
            if (phase_no == 2)
            begin
                hold_req++;
                noise_items(30);
            end
            while (items_sent - sent < 590)
            begin
                random_stream($urandom_range(8, 1));
                if ($urandom_range(4) == 0) noise_items(10);
            end
        end
        // large chunk count, a run set by a length byte, then an early end
        write_chunks(16'hc000);
        send_item(CMD_START, 0);
        send_item(CMD_BYTE, 8'h03);
        send_item(CMD_BYTE, 8'h0f);
        repeat (40) send_item(CMD_EMIT, 0);
        send_item(CMD_BYTE, 8'h17);
        send_item(CMD_END, 0);
        go_idle();

        fork
            begin
                while (sb.pending.size() != 0) @(negedge clk);
                repeat (10) @(negedge clk);
            end
            begin
                repeat (200000) @(negedge clk);
                sb.fails++;
            end
        join_any
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/lzrle_pkg.sv
sv/lzrle_hist.sv
sv/lzrle_ctrl.sv
sv/lz_rle_multimode_depacker.sv
dv/tb_lz_rle_multimode_depacker.sv
